>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL; define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> hdl/cqs_pkg.sv
// Types and constants for the circular queue with search.
`timescale 1ns / 1ps
package cqs_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int POS_W  = 4;

  typedef enum logic [1:0] {
    K_INSERT  = 2'd0,
    K_DELETE  = 2'd1,
    K_DISPLAY = 2'd2,
    K_SEARCH  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_LISTED    = 3'd4,
    ST_FOUND     = 3'd5,
    ST_NOT_FOUND = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DELETE,
    S_WALK
  } state_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] head;
    logic [IDX_W-1:0] tail;
    logic [CNT_W-1:0] count;
  } queue_stat_t;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

endpackage

>>> hdl/cqs_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
`timescale 1ns / 1ps
module cqs_ram #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/cqs_ctrl.sv
// Queue pointers, request sequencer and result registers.
`timescale 1ns / 1ps
module cqs_ctrl
  import cqs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               kind,
  input  logic signed [DATA_W-1:0] value,
  output logic                     strobe,
  output logic [2:0]               status,
  output logic signed [DATA_W-1:0] data_out,
  output logic [POS_W-1:0]         position,
  output logic                     last,
  output mem_req_t                 mem_req,
  input  logic [DATA_W-1:0]        rdata,
  output queue_stat_t              stat
);

  state_t            state, state_next;
  logic [IDX_W-1:0]  head, head_next;
  logic [IDX_W-1:0]  tail, tail_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  cur_idx, cur_idx_next;
  logic [CNT_W-1:0]  left, left_next;
  logic [DATA_W-1:0] key, key_next;
  logic              srch, srch_next;

  logic              strobe_next;
  status_t           status_next;
  logic [DATA_W-1:0] data_next;
  logic [POS_W-1:0]  pos_next;
  logic              last_next;
  logic              last_one;
  kind_t             op;

  assign op       = kind_t'(kind);
  assign last_one = (left == CNT_W'(1));
  assign busy     = (state != S_IDLE);
  assign stat     = '{head: head, tail: tail, count: count};

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= '0;
      tail   <= '0;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      head   <= head_next;
      tail   <= tail_next;
      count  <= count_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_idx  <= cur_idx_next;
    left     <= left_next;
    key      <= key_next;
    srch     <= srch_next;
    status   <= status_next;
    data_out <= data_next;
    position <= pos_next;
    last     <= last_next;
  end

  always_comb begin
    state_next    = state;
    head_next     = head;
    tail_next     = tail;
    count_next    = count;
    cur_idx_next  = cur_idx;
    left_next     = left;
    key_next      = key;
    srch_next     = srch;
    strobe_next   = 1'b0;
    status_next   = ST_INSERTED;
    data_next     = '0;
    pos_next      = '0;
    last_next     = 1'b1;
    mem_req.we    = 1'b0;
    mem_req.waddr = tail;
    mem_req.wdata = value;
    mem_req.raddr = head;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (op == K_INSERT) begin
            strobe_next = 1'b1;
            if (count == CNT_W'(DEPTH)) begin
              status_next = ST_FULL;
            end else begin
              mem_req.we = 1'b1;
              tail_next  = next_slot(tail);
              count_next = count + CNT_W'(1);
            end
          end else if (count == '0) begin
            strobe_next = 1'b1;
            status_next = ST_EMPTY;
          end else if (op == K_DELETE) begin
            // head word is being read this edge
            count_next = count - CNT_W'(1);
            if (count == CNT_W'(1)) begin
              head_next = '0;
              tail_next = '0;
            end else begin
              head_next = next_slot(head);
            end
            state_next = S_DELETE;
          end else begin
            cur_idx_next = head;
            left_next    = count;
            key_next     = value;
            srch_next    = (op == K_SEARCH);
            state_next   = S_WALK;
          end
        end
      end

      S_DELETE: begin
        strobe_next = 1'b1;
        status_next = ST_REMOVED;
        data_next   = rdata;
        state_next  = S_IDLE;
      end

      S_WALK: begin
        // rdata holds entry cur_idx; fetch the following slot meanwhile
        mem_req.raddr = next_slot(cur_idx);
        if (srch && (rdata == key)) begin
          strobe_next = 1'b1;
          status_next = ST_FOUND;
          pos_next    = POS_W'(cur_idx);
          state_next  = S_IDLE;
        end else if (srch && last_one) begin
          strobe_next = 1'b1;
          status_next = ST_NOT_FOUND;
          state_next  = S_IDLE;
        end else if (srch) begin
          cur_idx_next = next_slot(cur_idx);
          left_next    = left - CNT_W'(1);
        end else begin
          strobe_next = 1'b1;
          status_next = ST_LISTED;
          data_next   = rdata;
          last_next   = last_one;
          if (last_one) begin
            state_next = S_IDLE;
          end else begin
            cur_idx_next = next_slot(cur_idx);
            left_next    = left - CNT_W'(1);
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/circular_queue_with_search.sv
// Top level of the circular queue with search.
//
// Usage: a request is taken at a rising edge with start high and busy low;
// kind picks insert, delete, display or search, value is the word to insert
// or to look for. Results come out one per cycle on status, data_out,
// position and last, each marked by strobe for exactly one cycle; last
// flags the final result of a request. The receiver cannot hold results off.
// Timing: insert (or a full/empty report) gives its result the cycle after
// the request and busy stays low, so requests of that kind run every cycle.
// Delete reads the head word, then reports it. Display walks the held entries
// from head, one result per cycle; search ends at the first match or the last
// entry. The entry RAM's single read port paces walks, one entry per cycle.
// Reset (rst, synchronous) empties the queue and sets head and tail to zero;
// RAM contents are not cleared, so no clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module circular_queue_with_search
  import cqs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               kind,
  input  logic signed [DATA_W-1:0] value,
  output logic                     strobe,
  output logic [2:0]               status,
  output logic signed [DATA_W-1:0] data_out,
  output logic [POS_W-1:0]         position,
  output logic                     last
);

  mem_req_t          mem_req;
  logic [DATA_W-1:0] rdata;
  queue_stat_t       stat;

  cqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .kind     (kind),
    .value    (value),
    .strobe   (strobe),
    .status   (status),
    .data_out (data_out),
    .position (position),
    .last     (last),
    .mem_req  (mem_req),
    .rdata    (rdata),
    .stat     (stat)
  );

  cqs_ram #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  `ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1, stat.count <= CNT_W'(DEPTH), "count overflow")
  `ASSERT_IMPLIES(a_ptr_count, clk, rst, 1'b1, IDX_W'(stat.tail - stat.head) == IDX_W'(stat.count), "pointers disagree with count")
  `ASSERT_NEXT(a_insert_result, clk, rst, start && !busy && (kind == K_INSERT), strobe && last && !busy, "insert gave no result")

endmodule

>>> bench/tb_top.sv
// Testbench for circular_queue_with_search: random and directed requests, scoreboard check.
`timescale 1ns / 1ps
module tb_top;
  import cqs_pkg::*;

  typedef struct {
    status_t            status;
    logic signed [31:0] data;
    logic [3:0]         position;
    logic               last;
  } queue_result_t;

  typedef enum {PH_FILL, PH_CHURN, PH_DRAIN, PH_NOISE} mix_t;

  class queue_scoreboard;
    logic signed [31:0] slot_word [DEPTH];
    int unsigned        head_slot;
    int unsigned        tail_slot;
    int unsigned        fill;
    queue_result_t      pending_results [$];
    int unsigned        errors;

    function new();
      head_slot = 0;
      tail_slot = 0;
      fill      = 0;
      errors    = 0;
      foreach (slot_word[i]) slot_word[i] = '0;
    endfunction

    function int unsigned step(int unsigned i);
      return (i + 1) % DEPTH;
    endfunction

    function void push_result(status_t s, logic signed [31:0] d, int unsigned p, bit l);
      queue_result_t r;
      r.status   = s;
      r.data     = d;
      r.position = p[3:0];
      r.last     = l;
      pending_results.push_back(r);
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // a word currently held (random when empty), for searches that should hit
    function logic signed [31:0] pick_held();
      if (fill == 0) return $urandom;
      return slot_word[(head_slot + $urandom_range(fill - 1)) % DEPTH];
    endfunction

    function void note_request(kind_t k, logic signed [31:0] v);
      int unsigned        slot;
      int unsigned        n;
      bit                 hit;
      logic signed [31:0] word;
      if (k == K_INSERT) begin
        if (fill == DEPTH) begin
          push_result(ST_FULL, '0, 0, 1'b1);
        end else begin
          slot_word[tail_slot] = v;
          tail_slot = step(tail_slot);
          fill++;
          push_result(ST_INSERTED, '0, 0, 1'b1);
        end
      end else if (fill == 0) begin
        push_result(ST_EMPTY, '0, 0, 1'b1);
      end else if (k == K_DELETE) begin
        word = slot_word[head_slot];
        fill--;
        // draining sends both pointers back to slot 0
        if (fill == 0) begin
          head_slot = 0;
          tail_slot = 0;
        end else begin
          head_slot = step(head_slot);
        end
        push_result(ST_REMOVED, word, 0, 1'b1);
      end else if (k == K_DISPLAY) begin
        slot = head_slot;
        for (n = 0; n < fill; n++) begin
          push_result(ST_LISTED, slot_word[slot], 0, n + 1 == fill);
          slot = step(slot);
        end
      end else begin
        slot = head_slot;
        hit  = 1'b0;
        for (n = 0; n < fill && !hit; n++) begin
          if (slot_word[slot] == v) hit = 1'b1;
          else slot = step(slot);
        end
        if (hit) push_result(ST_FOUND, '0, slot, 1'b1);
        else push_result(ST_NOT_FOUND, '0, 0, 1'b1);
      end
    endfunction

    function void check_result(logic [2:0] st, logic signed [31:0] d, logic [3:0] p,
                               logic l);
      queue_result_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d data_out %0d position %0d last %0b",
               st, d, p, l);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (d !== e.data) begin
        $error("data_out: expected %0d, got %0d", e.data, d);
        errors++;
      end
      if (p !== e.position) begin
        $error("position: expected %0d, got %0d", e.position, p);
        errors++;
      end
      if (l !== e.last) begin
        $error("last: expected %0b, got %0b", e.last, l);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [1:0]               kind = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     busy;
  logic                     strobe;
  logic [2:0]               status;
  logic signed [DATA_W-1:0] data_out;
  logic [POS_W-1:0]         position;
  logic                     last;

  queue_scoreboard sb = new();
  bit              gaps_on = 1'b1;

  circular_queue_with_search dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .kind     (kind),
    .value    (value),
    .strobe   (strobe),
    .status   (status),
    .data_out (data_out),
    .position (position),
    .last     (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ($isunknown(strobe)) begin
        $error("strobe is unknown");
        sb.errors++;
      end else if (strobe) begin
        sb.check_result(status, data_out, position, last);
      end
    end
  end

  // present one request and hold it until taken
  task automatic issue(input kind_t k, input logic signed [31:0] v);
    while (gaps_on && $urandom_range(99) < 23) begin
      start <= 1'b0;
      kind  <= 2'($urandom_range(3));
      value <= $urandom;
      @(posedge clk);
    end
    start <= 1'b1;
    kind  <= k;
    value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(k, v);
  endtask

  function automatic logic signed [31:0] pick_word();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) return 32'($signed($urandom_range(8)) - 4);
    if (roll < 48) return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    return $urandom;
  endfunction

  function automatic kind_t pick_kind(mix_t mix);
    int unsigned roll;
    roll = $urandom_range(99);
    case (mix)
      PH_FILL: begin
        if (roll < 85) return K_INSERT;
        if (roll < 93) return K_SEARCH;
        if (roll < 97) return K_DISPLAY;
        return K_DELETE;
      end
      PH_CHURN: begin
        if (roll < 35) return K_INSERT;
        if (roll < 70) return K_DELETE;
        if (roll < 90) return K_SEARCH;
        return K_DISPLAY;
      end
      PH_DRAIN: begin
        if (roll < 75) return K_DELETE;
        if (roll < 87) return K_SEARCH;
        if (roll < 92) return K_DISPLAY;
        return K_INSERT;
      end
      default: return kind_t'($urandom_range(3));
    endcase
  endfunction

  initial begin
    int                 sent;
    int                 run_len;
    mix_t               mix;
    kind_t              k;
    logic signed [31:0] w;
    logic signed [31:0] probe;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue, then extremes, duplicates, first match, drain back to slot 0
    issue(K_DELETE, $urandom);
    issue(K_DISPLAY, $urandom);
    issue(K_SEARCH, 32'sd0);
    issue(K_INSERT, 32'sh7fff_ffff);
    issue(K_INSERT, 32'sh8000_0000);
    issue(K_INSERT, 32'sd0);
    issue(K_INSERT, -32'sd1);
    issue(K_INSERT, 32'sh5a5a_a5a5);
    issue(K_INSERT, -32'sd1);
    issue(K_DISPLAY, $urandom);
    issue(K_SEARCH, -32'sd1);
    issue(K_SEARCH, 32'sh8000_0000);
    issue(K_SEARCH, 32'sd12345);
    issue(K_DELETE, $urandom);
    issue(K_SEARCH, -32'sd1);
    repeat (5) issue(K_DELETE, $urandom);
    probe = $urandom;
    issue(K_INSERT, probe);
    issue(K_SEARCH, probe);
    issue(K_DELETE, $urandom);

    sent = 0;
    mix  = PH_FILL;
    while (sent < 390) begin
      run_len = $urandom_range(20, 45);
      repeat (run_len) begin
        gaps_on = !(sent >= 150 && sent < 260);
        k = pick_kind(mix);
        if (k == K_SEARCH && $urandom_range(99) < 55) w = sb.pick_held();
        else w = pick_word();
        issue(k, w);
        sent++;
      end
      if (sb.fill < 4) mix = $urandom_range(3) == 0 ? PH_NOISE : PH_FILL;
      else if (sb.fill > 12) mix = $urandom_range(1) ? PH_CHURN : PH_DRAIN;
      else mix = mix_t'($urandom_range(3));
    end

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("circular_queue_with_search test passed");
    end else begin
      $display("circular_queue_with_search test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("circular_queue_with_search test failed");
    $finish;
  end

endmodule
